FILE: design/emdp_pkg.sv
package emdp_pkg;

  localparam int unsigned MAX_MESSAGE_BYTES = 2048;
  localparam int unsigned LEN_W             = 12;
  localparam int unsigned MINF_W            = 8;
  localparam int unsigned CFG_DATA_W        = 12;
  localparam int unsigned OUT_TDATA_W       = 144;

  // register indexes
  localparam logic CFG_MESSAGE_LENGTH = 1'b0;
  localparam logic CFG_MIN_FIELDS     = 1'b1;

  localparam logic [LEN_W-1:0]  MESSAGE_LENGTH_RST = LEN_W'(600);
  localparam logic [MINF_W-1:0] MIN_FIELDS_RST     = MINF_W'(1);
  localparam logic [LEN_W-1:0]  MAX_LEN            = LEN_W'(MAX_MESSAGE_BYTES);

  // header layout
  localparam logic [7:0]       ID_BYTE0       = 8'h53;
  localparam logic [7:0]       ID_BYTE1       = 8'h4d;
  localparam logic [7:0]       ID_BYTE2       = 8'h41;
  localparam logic [LEN_W-1:0] ID_LEN         = LEN_W'(3);
  localparam logic [LEN_W-1:0] HDR_LAST_POS   = LEN_W'(19);
  localparam logic [3:0]       WORD_BYTES     = 4'd4;
  localparam logic [3:0]       SUM_BYTES      = 4'd8;
  localparam logic [7:0]       TYPE_ACTUAL    = 8'd4;
  localparam logic [7:0]       TYPE_SUMMED    = 8'd8;

  // parse phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SERIAL = 3'd1;
  localparam logic [2:0] PH_STAMP  = 3'd2;
  localparam logic [2:0] PH_FHDR   = 3'd3;
  localparam logic [2:0] PH_VALUE  = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;
  localparam logic [2:0] PH_ERROR  = 3'd6;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT = 3'd1;
  localparam logic [2:0] ST_BAD_ID    = 3'd2;
  localparam logic [2:0] ST_BAD_FMT   = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  // result kinds
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic        kind;
    logic [7:0]  field_address;
    logic        is_summed;
    logic [63:0] field_value;
    logic [31:0] serial_number;
    logic [31:0] time_stamp;
    logic [2:0]  status;
    logic        last;
  } result_t;

  function automatic logic [7:0] ident_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = ID_BYTE0;
      2'd1:    b = ID_BYTE1;
      2'd2:    b = ID_BYTE2;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: design/energy_meter_datagram_parser.sv
// The result words of an accepted byte are written into the registered result queue at the edge that accepts it.
// Throughput: one input byte per cycle; a byte that ends a record and the datagram
// queues two result words, and the 4-word result queue drops s_axis_tready while
// it holds more than two words.
// Reset (rst_ni low, asynchronous): parser state cleared to the header phase, queue
// emptied, message_length = 600, min_fields = 1.
module energy_meter_datagram_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write port
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [emdp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input bytes
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [7:0] data_byte
  input  logic                               s_axis_tlast,  // end_of_message
  // results
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] field_address, [8] is_summed, [72:9] field_value, [104:73] serial_number,
  // [136:105] time_stamp, [139:137] status, [143:140] zero
  output logic [emdp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tuser,  // kind
  output logic                               m_axis_tlast   // last
);

  localparam int unsigned LW = emdp_pkg::LEN_W;
  localparam int unsigned MW = emdp_pkg::MINF_W;
  localparam int unsigned PW = emdp_pkg::QPTR_W;
  localparam int unsigned CW = emdp_pkg::QCNT_W;

  // configuration
  logic [LW-1:0] message_length_q;
  logic [MW-1:0] min_fields_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      message_length_q <= emdp_pkg::MESSAGE_LENGTH_RST;
      min_fields_q     <= emdp_pkg::MIN_FIELDS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        emdp_pkg::CFG_MESSAGE_LENGTH: message_length_q <= cfg_data_i[LW-1:0];
        emdp_pkg::CFG_MIN_FIELDS:     min_fields_q     <= cfg_data_i[MW-1:0];
        default: ;
      endcase
    end
  end

  // parser state
  logic [LW-1:0] pos_q,     pos_d;
  logic [2:0]    phase_q,   phase_d;
  logic [3:0]    sub_q,     sub_d;
  logic [MW-1:0] fcount_q,  fcount_d;
  logic [63:0]   shift_q,   shift_d;
  logic [7:0]    addr_q,    addr_d;
  logic          summed_q,  summed_d;
  logic [31:0]   serial_q,  serial_d;
  logic [31:0]   stamp_q,   stamp_d;
  logic [2:0]    err_q,     err_d;

  // post-parse values, before the end-of-message clear
  logic [LW-1:0] pos_p;
  logic [2:0]    phase_p;
  logic [3:0]    sub_p;
  logic [MW-1:0] fcount_p;
  logic [63:0]   shift_p;
  logic [7:0]    addr_p;
  logic          summed_p;
  logic [31:0]   serial_p;
  logic [31:0]   stamp_p;
  logic [2:0]    err_p;

  logic [LW-1:0] eff_len;
  logic          in_range;
  logic [7:0]    b;
  logic [3:0]    sub_inc;
  logic [63:0]   val_next;
  logic          rec_valid;
  logic [63:0]   rec_value;
  logic          fhdr_fmt_bad;
  logic          fhdr_type_bad;
  logic          fhdr_ok_end;
  logic [2:0]    st_code;
  logic          s_accept;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign eff_len  = (message_length_q < emdp_pkg::MAX_LEN) ? message_length_q
                                                           : emdp_pkg::MAX_LEN;
  assign in_range = pos_q < eff_len;
  assign b        = s_axis_tdata;
  assign sub_inc  = sub_q + 4'd1;
  assign val_next = {shift_q[55:0], b};

  // field header decode: bytes 0..2 are in shift_q, byte 3 is the current one
  assign fhdr_fmt_bad  = (shift_q[23:16] != 8'h00) || (b != 8'h00);
  assign fhdr_type_bad = (shift_q[7:0] != emdp_pkg::TYPE_ACTUAL) &&
                         (shift_q[7:0] != emdp_pkg::TYPE_SUMMED);
  assign fhdr_ok_end   = fcount_q >= min_fields_q;

  always_comb begin
    pos_p     = pos_q;
    phase_p   = phase_q;
    sub_p     = sub_q;
    fcount_p  = fcount_q;
    shift_p   = shift_q;
    addr_p    = addr_q;
    summed_p  = summed_q;
    serial_p  = serial_q;
    stamp_p   = stamp_q;
    err_p     = err_q;
    rec_valid = 1'b0;
    rec_value = summed_q ? val_next : {{32{val_next[31]}}, val_next[31:0]};

    if (in_range) begin
      pos_p = pos_q + LW'(1);
      case (phase_q)
        emdp_pkg::PH_HEADER: begin
          if (pos_q < emdp_pkg::ID_LEN && b != emdp_pkg::ident_byte(pos_q[1:0])) begin
            phase_p = emdp_pkg::PH_ERROR;
            err_p   = emdp_pkg::ST_BAD_ID;
          end else if (pos_q == emdp_pkg::HDR_LAST_POS) begin
            phase_p = emdp_pkg::PH_SERIAL;
            sub_p   = 4'd0;
          end
        end
        emdp_pkg::PH_SERIAL: begin
          serial_p = {serial_q[23:0], b};
          sub_p    = sub_inc;
          if (sub_inc == emdp_pkg::WORD_BYTES) begin
            phase_p = emdp_pkg::PH_STAMP;
            sub_p   = 4'd0;
          end
        end
        emdp_pkg::PH_STAMP: begin
          stamp_p = {stamp_q[23:0], b};
          sub_p   = sub_inc;
          if (sub_inc == emdp_pkg::WORD_BYTES) begin
            phase_p = emdp_pkg::PH_FHDR;
            sub_p   = 4'd0;
            shift_p = '0;
          end
        end
        emdp_pkg::PH_FHDR: begin
          shift_p = {32'h0, shift_q[23:0], b};
          sub_p   = sub_inc;
          if (sub_inc == emdp_pkg::WORD_BYTES) begin
            sub_p   = 4'd0;
            shift_p = '0;
            if (fhdr_fmt_bad || fhdr_type_bad) begin
              if (fhdr_ok_end) begin
                phase_p = emdp_pkg::PH_DONE;
              end else begin
                phase_p = emdp_pkg::PH_ERROR;
                err_p   = fhdr_fmt_bad ? emdp_pkg::ST_BAD_FMT : emdp_pkg::ST_BAD_ID;
              end
            end else begin
              addr_p   = shift_q[15:8];
              summed_p = (shift_q[7:0] == emdp_pkg::TYPE_SUMMED);
              phase_p  = emdp_pkg::PH_VALUE;
            end
          end
        end
        emdp_pkg::PH_VALUE: begin
          shift_p = val_next;
          sub_p   = sub_inc;
          if (sub_inc == (summed_q ? emdp_pkg::SUM_BYTES : emdp_pkg::WORD_BYTES)) begin
            rec_valid = 1'b1;
            if (fcount_q != {MW{1'b1}}) begin
              fcount_p = fcount_q + MW'(1);
            end
            phase_p = emdp_pkg::PH_FHDR;
            sub_p   = 4'd0;
            shift_p = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pos_p < eff_len) begin
      st_code = emdp_pkg::ST_TOO_SHORT;
    end else if (phase_p == emdp_pkg::PH_ERROR) begin
      st_code = err_p;
    end else if (phase_p <= emdp_pkg::PH_STAMP) begin
      st_code = emdp_pkg::ST_TOO_SHORT;
    end else if (phase_p == emdp_pkg::PH_VALUE) begin
      st_code = emdp_pkg::ST_TRUNC;
    end else begin
      st_code = emdp_pkg::ST_OK;
    end
  end

  always_comb begin
    if (s_axis_tlast) begin
      pos_d    = '0;
      phase_d  = emdp_pkg::PH_HEADER;
      sub_d    = '0;
      fcount_d = '0;
      shift_d  = '0;
      addr_d   = '0;
      summed_d = 1'b0;
      serial_d = '0;
      stamp_d  = '0;
      err_d    = emdp_pkg::ST_OK;
    end else begin
      pos_d    = pos_p;
      phase_d  = phase_p;
      sub_d    = sub_p;
      fcount_d = fcount_p;
      shift_d  = shift_p;
      addr_d   = addr_p;
      summed_d = summed_p;
      serial_d = serial_p;
      stamp_d  = stamp_p;
      err_d    = err_p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= emdp_pkg::PH_HEADER;
      sub_q    <= '0;
      fcount_q <= '0;
      shift_q  <= '0;
      addr_q   <= '0;
      summed_q <= 1'b0;
      serial_q <= '0;
      stamp_q  <= '0;
      err_q    <= emdp_pkg::ST_OK;
    end else if (s_accept) begin
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      sub_q    <= sub_d;
      fcount_q <= fcount_d;
      shift_q  <= shift_d;
      addr_q   <= addr_d;
      summed_q <= summed_d;
      serial_q <= serial_d;
      stamp_q  <= stamp_d;
      err_q    <= err_d;
    end
  end

  // result words
  emdp_pkg::result_t rec_word, st_word;

  always_comb begin
    rec_word               = '0;
    rec_word.kind          = emdp_pkg::KIND_RECORD;
    rec_word.field_address = addr_q;
    rec_word.is_summed     = summed_q;
    rec_word.field_value   = rec_value;

    st_word                = '0;
    st_word.kind           = emdp_pkg::KIND_STATUS;
    st_word.serial_number  = serial_p;
    st_word.time_stamp     = stamp_p;
    st_word.status         = st_code;
    st_word.last           = 1'b1;
  end

  // result queue, up to two pushes per cycle
  emdp_pkg::result_t queue_q [emdp_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [CW-1:0] count_q, count_d;
  logic          push_rec, push_st, pop;
  logic [1:0]    push_n;

  assign push_rec  = s_accept && rec_valid;
  assign push_st   = s_accept && s_axis_tlast;
  assign push_n    = {1'b0, push_rec} + {1'b0, push_st};
  assign pop       = m_axis_tvalid && m_axis_tready;
  assign wr_ptr_nx = wr_ptr_q + PW'(1);
  assign wr_ptr_d  = wr_ptr_q + PW'(push_n);
  assign rd_ptr_d  = rd_ptr_q + PW'(pop);
  assign count_d   = count_q + CW'(push_n) - CW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_rec) begin
      queue_q[wr_ptr_q] <= rec_word;
    end
    if (push_st) begin
      queue_q[push_rec ? wr_ptr_nx : wr_ptr_q] <= st_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  emdp_pkg::result_t head;
  assign head = queue_q[rd_ptr_q];

  assign s_axis_tready = count_q <= CW'(emdp_pkg::QUEUE_DEPTH - 2);
  assign m_axis_tvalid = count_q != '0;
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = {4'h0, head.status, head.time_stamp, head.serial_number,
                          head.field_value, head.is_summed, head.field_address};

endmodule

FILE: design/emdp_checker.sv
module emdp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [emdp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tuser,
  input logic                             m_axis_tlast
);

  // status words close a datagram, record words never do
  a_last_on_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == emdp_pkg::KIND_STATUS)))
    else $error("tlast does not match result kind");

  a_record_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == emdp_pkg::KIND_RECORD) |->
      (m_axis_tdata[143:73] == '0))
    else $error("record word carries status, serial or stamp bits");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == emdp_pkg::KIND_STATUS) |->
      (m_axis_tdata[72:0] == '0 && m_axis_tdata[139:137] <= emdp_pkg::ST_TRUNC))
    else $error("status word has record bits or an unknown code");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result word changed");

endmodule

bind energy_meter_datagram_parser emdp_checker u_emdp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/tb_energy_meter_datagram_parser.sv
`timescale 1ns / 100ps

module tb_energy_meter_datagram_parser;
  import emdp_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int ITEMS      = 950;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic                         cfg_index_i = CFG_MESSAGE_LENGTH;
  logic [CFG_DATA_W-1:0]        cfg_data_i = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata = '0;  // [7:0] data_byte
  logic                         s_axis_tlast = 1'b0;  // end_of_message
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  // [7:0] field_address, [8] is_summed, [72:9] field_value, [104:73] serial_number,
  // [136:105] time_stamp, [139:137] status, [143:140] zero
  logic [OUT_TDATA_W-1:0]       m_axis_tdata;
  logic                         m_axis_tuser;  // kind
  logic                         m_axis_tlast;  // last

  energy_meter_datagram_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // Tracks the parser state byte by byte and holds the result words it owes.
  class datagram_checker;
    logic [LEN_W-1:0]  msg_len;
    logic [MINF_W-1:0] min_fields;
    logic [LEN_W-1:0]  byte_pos;
    logic [2:0]        phase;
    logic [3:0]        sub_cnt;
    logic [7:0]        field_cnt;
    logic [63:0]       shift_reg;
    logic [7:0]        cur_addr;
    logic              cur_summed;
    logic [31:0]       serial;
    logic [31:0]       stamp;
    logic [2:0]        err_code;
    result_t           expected_words[$];
    int                mismatches;
    int                records_checked;
    int                statuses_checked;

    function new();
      msg_len          = MESSAGE_LENGTH_RST;
      min_fields       = MIN_FIELDS_RST;
      mismatches       = 0;
      records_checked  = 0;
      statuses_checked = 0;
      clear_datagram();
    endfunction

    function void clear_datagram();
      byte_pos   = '0;
      phase      = PH_HEADER;
      sub_cnt    = '0;
      field_cnt  = '0;
      shift_reg  = '0;
      cur_addr   = '0;
      cur_summed = 1'b0;
      serial     = '0;
      stamp      = '0;
      err_code   = ST_OK;
    endfunction

    function void set_register(logic idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_MESSAGE_LENGTH) msg_len = val[LEN_W-1:0];
      else min_fields = val[MINF_W-1:0];
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // a bad field header only fails while too few records have been parsed
    function void end_or_fail(logic [2:0] code);
      if (field_cnt >= min_fields) begin
        phase = PH_DONE;
      end else begin
        err_code = code;
        phase    = PH_ERROR;
      end
    endfunction

    function void take_byte(logic [7:0] b, logic eom);
      logic [LEN_W-1:0] lim;
      logic [7:0]       id_want;
      logic [7:0]       h0, ha, ht, h3;
      logic [63:0]      v;
      result_t          r;
      lim = (msg_len < MAX_LEN) ? msg_len : MAX_LEN;
      if (byte_pos < lim) begin
        case (phase)
          PH_HEADER: begin
            case (byte_pos[1:0])
              2'd0:    id_want = ID_BYTE0;
              2'd1:    id_want = ID_BYTE1;
              default: id_want = ID_BYTE2;
            endcase
            if (byte_pos < ID_LEN && b != id_want) begin
              err_code = ST_BAD_ID;
              phase    = PH_ERROR;
            end else if (byte_pos == HDR_LAST_POS) begin
              phase   = PH_SERIAL;
              sub_cnt = '0;
            end
          end
          PH_SERIAL: begin
            serial  = {serial[23:0], b};
            sub_cnt = sub_cnt + 4'd1;
            if (sub_cnt == WORD_BYTES) begin
              phase   = PH_STAMP;
              sub_cnt = '0;
            end
          end
          PH_STAMP: begin
            stamp   = {stamp[23:0], b};
            sub_cnt = sub_cnt + 4'd1;
            if (sub_cnt == WORD_BYTES) begin
              phase     = PH_FHDR;
              sub_cnt   = '0;
              shift_reg = '0;
            end
          end
          PH_FHDR: begin
            shift_reg = {32'd0, shift_reg[23:0], b};
            sub_cnt   = sub_cnt + 4'd1;
            if (sub_cnt == WORD_BYTES) begin
              {h0, ha, ht, h3} = shift_reg[31:0];
              sub_cnt   = '0;
              shift_reg = '0;
              if (h0 != 8'd0 || h3 != 8'd0) begin
                end_or_fail(ST_BAD_FMT);
              end else if (ht != TYPE_ACTUAL && ht != TYPE_SUMMED) begin
                end_or_fail(ST_BAD_ID);
              end else begin
                cur_addr   = ha;
                cur_summed = (ht == TYPE_SUMMED);
                phase      = PH_VALUE;
              end
            end
          end
          PH_VALUE: begin
            shift_reg = {shift_reg[55:0], b};
            sub_cnt   = sub_cnt + 4'd1;
            if (sub_cnt == (cur_summed ? SUM_BYTES : WORD_BYTES)) begin
              v = cur_summed ? shift_reg : {{32{shift_reg[31]}}, shift_reg[31:0]};
              r               = '0;
              r.kind          = KIND_RECORD;
              r.field_address = cur_addr;
              r.is_summed     = cur_summed;
              r.field_value   = v;
              expected_words  = {expected_words, r};
              if (field_cnt != 8'hFF) field_cnt = field_cnt + 8'd1;
              phase     = PH_FHDR;
              sub_cnt   = '0;
              shift_reg = '0;
            end
          end
          default: ;
        endcase
        byte_pos = byte_pos + LEN_W'(1);
      end
      if (eom) begin
        r               = '0;
        r.kind          = KIND_STATUS;
        r.serial_number = serial;
        r.time_stamp    = stamp;
        r.last          = 1'b1;
        // missing bytes win over any other outcome
        if (byte_pos < lim) r.status = ST_TOO_SHORT;
        else if (phase == PH_ERROR) r.status = err_code;
        else if (phase <= PH_STAMP) r.status = ST_TOO_SHORT;
        else if (phase == PH_VALUE) r.status = ST_TRUNC;
        else r.status = ST_OK;
        expected_words = {expected_words, r};
        clear_datagram();
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 30) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_word(logic [OUT_TDATA_W-1:0] d, logic k, logic l);
      result_t e;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing expected", d));
        return;
      end
      e = expected_words[0];
      expected_words.delete(0);
      if (e.kind == KIND_RECORD) records_checked++;
      else statuses_checked++;
      compare("kind", 64'(k), 64'(e.kind));
      compare("field_address", 64'(d[7:0]), 64'(e.field_address));
      compare("is_summed", 64'(d[8]), 64'(e.is_summed));
      compare("field_value", d[72:9], e.field_value);
      compare("serial_number", 64'(d[104:73]), 64'(e.serial_number));
      compare("time_stamp", 64'(d[136:105]), 64'(e.time_stamp));
      compare("status", 64'(d[139:137]), 64'(e.status));
      compare("zero fill", 64'(d[143:140]), 64'd0);
      compare("last", 64'(l), 64'(e.last));
    endtask
  endclass

  datagram_checker dgram_check;
  logic [7:0]      dgram[$];
  int unsigned     cur_len = 600;
  int              in_calm = 0;
  int              out_calm = 0;
  int              parsed_bytes = 0;
  int              sent_bytes = 0;
  int              datagrams_sent = 0;
  int              idle_cycles = 0;

  // wait before each word; sometimes a run of back-to-back words
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic void append_byte(input logic [7:0] v);
    dgram = {dgram, v};
  endfunction

  function automatic void put_field_header(input logic [7:0] b0, input logic [7:0] addr,
                                           input logic [7:0] typ, input logic [7:0] b3);
    append_byte(b0);
    append_byte(addr);
    append_byte(typ);
    append_byte(b3);
  endfunction

  function automatic void put_header(input bit good_id);
    int p;
    append_byte(ID_BYTE0);
    append_byte(ID_BYTE1);
    append_byte(ID_BYTE2);
    repeat (25) append_byte(8'($urandom));
    if (!good_id) begin
      p = $urandom_range(0, 2);
      dgram[p] = dgram[p] ^ 8'($urandom_range(1, 255));
    end
  endfunction

  function automatic void put_record(input logic [7:0] addr, input bit summed,
                                     input logic [63:0] value);
    put_field_header(8'h00, addr, summed ? TYPE_SUMMED : TYPE_ACTUAL, 8'h00);
    for (int i = (summed ? 7 : 3); i >= 0; i--) append_byte(value[8*i +: 8]);
  endfunction

  function automatic void put_bad_record();
    logic [7:0] typ;
    case ($urandom_range(0, 2))
      0: put_field_header(8'($urandom_range(1, 255)), 8'($urandom), TYPE_ACTUAL, 8'h00);
      1: put_field_header(8'h00, 8'($urandom), TYPE_SUMMED, 8'($urandom_range(1, 255)));
      default: begin
        typ = 8'($urandom);
        while (typ == TYPE_ACTUAL || typ == TYPE_SUMMED) typ = 8'($urandom);
        put_field_header(8'h00, 8'($urandom), typ, 8'h00);
      end
    endcase
  endfunction

  function automatic void pad_to(input int n);
    while (dgram.size() < n) append_byte(8'($urandom));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eom);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eom;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_datagram();
    int unsigned lim;
    lim = (cur_len < MAX_MESSAGE_BYTES) ? cur_len : MAX_MESSAGE_BYTES;
    foreach (dgram[i]) send_byte(dgram[i], i == dgram.size() - 1);
    parsed_bytes += (dgram.size() < lim) ? dgram.size() : lim;
    sent_bytes += dgram.size();
    datagrams_sent++;
    dgram.delete();
  endtask

  // drain everything owed, then leave room for a word still in the pipe
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (dgram_check.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    dgram_check.set_register(idx, val);
  endtask

  task automatic configure(input int unsigned len, input int unsigned minf);
    settle();
    write_reg(CFG_MESSAGE_LENGTH, CFG_DATA_W'(len));
    write_reg(CFG_MIN_FIELDS, CFG_DATA_W'(minf));
    cfg_we_i <= 1'b0;
    cur_len = len;
  endtask

  task automatic random_datagram();
    int unsigned target;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 11) target = cur_len;
    else if (pick < 15) target = $urandom_range(1, (cur_len > 1) ? cur_len - 1 : 1);
    else target = cur_len + $urandom_range(1, 10);
    if (target == 0) target = 1;
    put_header($urandom_range(0, 11) != 0);
    while (dgram.size() < target) begin
      if ($urandom_range(0, 9) == 0) put_bad_record();
      else put_record(8'($urandom), $urandom_range(0, 1), {$urandom, $urandom});
    end
    while (dgram.size() > target) void'(dgram.pop_back());
    send_datagram();
  endtask

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) dgram_check.take_byte(s_axis_tdata, s_axis_tlast);
    if (m_axis_tvalid && m_axis_tready)
      dgram_check.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_gap(out_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    int unsigned len;
    int unsigned minf;
    int          batch_left;
    dgram_check = new();
    batch_left  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(48, 1);
    // two records of extreme values, the second ends on the final byte
    put_header(1);
    put_record(8'hFF, 1'b0, 64'h0000_0000_8000_0000);
    put_record(8'h00, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
    send_datagram();
    put_header(1);
    put_record(8'h80, 1'b0, 64'h0000_0000_7FFF_FFFF);
    put_record(8'h7F, 1'b1, 64'h8000_0000_0000_0000);
    send_datagram();
    put_header(0);
    pad_to(48);
    send_datagram();
    put_header(1);
    void'(dgram.pop_back());
    send_datagram();
    // bad first byte, bad fourth byte, bad type, all before min_fields
    put_header(1);
    put_field_header(8'h01, 8'h05, TYPE_ACTUAL, 8'h00);
    pad_to(48);
    send_datagram();
    put_header(1);
    put_field_header(8'h00, 8'h05, TYPE_SUMMED, 8'h02);
    pad_to(48);
    send_datagram();
    put_header(1);
    put_field_header(8'h00, 8'h05, 8'h07, 8'h00);
    pad_to(48);
    send_datagram();
    // limit falls inside an 8-byte value
    put_header(1);
    put_record(8'h11, 1'b1, 64'hFFFF_FFFF);
    put_record(8'h12, 1'b1, {$urandom, $urandom});
    send_datagram();
    // bad header after one record ends parsing normally, extra bytes ignored
    put_header(1);
    put_record(8'h13, 1'b0, 64'h0);
    put_field_header(8'h00, 8'h09, 8'h09, 8'h00);
    pad_to(53);
    send_datagram();

    configure(46, 0);
    // partial field header at the limit
    put_header(1);
    put_record(8'h21, 1'b0, {$urandom, $urandom});
    put_record(8'h22, 1'b0, {$urandom, $urandom});
    append_byte(8'h00);
    append_byte(8'h07);
    send_datagram();
    put_header(1);
    put_bad_record();
    pad_to(46);
    send_datagram();

    configure(60, 255);
    put_header(1);
    put_record(8'h31, 1'b1, {$urandom, $urandom});
    put_field_header(8'h04, 8'h32, TYPE_ACTUAL, 8'h00);
    pad_to(60);
    send_datagram();

    // limits that cut the header
    configure(10, 255);
    put_header(1);
    pad_to(12);
    while (dgram.size() > 12) void'(dgram.pop_back());
    send_datagram();
    put_header(0);
    while (dgram.size() > 10) void'(dgram.pop_back());
    send_datagram();
    configure(0, 255);
    append_byte(ID_BYTE0);
    send_datagram();

    // register above the byte limit: a short datagram still reads as too short
    configure(4095, 2);
    put_header(1);
    put_record(8'h41, 1'b1, {$urandom, $urandom});
    send_datagram();

    while (sent_bytes < ITEMS) begin
      if (batch_left == 0) begin
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 27) : $urandom_range(28, 120);
        case ($urandom_range(0, 9))
          0:       minf = 255;
          1:       minf = $urandom_range(0, 255);
          default: minf = $urandom_range(0, 3);
        endcase
        configure(len, minf);
        batch_left = $urandom_range(2, 4);
      end
      random_datagram();
      batch_left--;
    end

    settle();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d datagrams, %0d bytes (%0d inside the limit) over varied lengths and minimums",
             datagrams_sent, sent_bytes, parsed_bytes);
    $display("Checked %0d field records and %0d status words",
             dgram_check.records_checked, dgram_check.statuses_checked);
    if (dgram_check.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
